// ===== sv/etd_pkg.sv =====
// shared types and constants of the edge table dedup insert unit
package etd_pkg;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_VERTEX_BITS = 16;
    localparam int DEF_WEIGHT_BITS = 16;

    localparam int STATUS_BITS     = 2;
    localparam int OUT_WEIGHT_BITS = 16;
    localparam int OUT_SLOT_BITS   = 6;
    localparam int OUT_DATA_BITS   = STATUS_BITS + OUT_WEIGHT_BITS + OUT_SLOT_BITS;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_NEW       = 2'd0,
        ST_REVERSE   = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic dup;
        logic rev;
    } match_t;

endpackage

// ===== sv/edge_table_dedup_insert_unit.sv =====
// top level of the edge table dedup insert unit
//
//  channel   dir  fields (low bit up)                                 width
//  s_axis    in   from_vertex, to_vertex, offered_weight              48 by default
//  m_axis    out  insert_status[1:0], stored_weight[17:2], slot[23:18] 24
//
// from accept to result, the single table read port is swept once over all
// live entries and each entry read is compared against the word
// a duplicate ends the sweep at its slot
// aresetn clears the live count and control; the table needs no clearing
// s_axis_tready is high only while idle; a waiting result holds the block
// in its final cycle, so one new word is taken while a result is pending
module edge_table_dedup_insert_unit #(
    parameter int TABLE_DEPTH = etd_pkg::DEF_TABLE_DEPTH,
    parameter int VERTEX_BITS = etd_pkg::DEF_VERTEX_BITS,
    parameter int WEIGHT_BITS = etd_pkg::DEF_WEIGHT_BITS
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // from_vertex, to_vertex, offered_weight, zero pad
    input  logic [((2*VERTEX_BITS+WEIGHT_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // insert_status, stored_weight, entry_slot
    output logic [etd_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);
    import etd_pkg::*;

    localparam int SLOT_BITS = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS  = $clog2(TABLE_DEPTH + 1);

    state_t                 state_reg, state_next;
    logic [VERTEX_BITS-1:0] from_reg, from_next;
    logic [VERTEX_BITS-1:0] to_reg, to_next;
    logic [WEIGHT_BITS-1:0] wt_reg, wt_next;
    logic [CNT_BITS-1:0]    rd_idx_reg, rd_idx_next;
    logic                   cmp_valid_reg, cmp_valid_next;
    logic [SLOT_BITS-1:0]   cmp_idx_reg, cmp_idx_next;
    logic                   rev_found_reg, rev_found_next;
    logic [WEIGHT_BITS-1:0] rev_wt_reg, rev_wt_next;
    logic                   dup_reg, dup_next;
    logic [SLOT_BITS-1:0]   dup_slot_reg, dup_slot_next;
    logic [CNT_BITS-1:0]    count_reg, count_next;
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_DATA_BITS-1:0] m_data_reg, m_data_next;

    logic                   table_full;
    logic                   wr_en;
    logic                   rd_en;
    logic [WEIGHT_BITS-1:0] rd_weight;
    match_t                 match;
    status_t                res_status;
    logic [WEIGHT_BITS-1:0] res_weight;
    logic [SLOT_BITS-1:0]   res_slot;
    logic [31:0]            res_weight_wide;
    logic [31:0]            res_slot_wide;
    logic                   finish_fire;

    etd_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VERTEX_BITS (VERTEX_BITS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_table (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (count_reg[SLOT_BITS-1:0]),
        .wr_from   (from_reg),
        .wr_to     (to_reg),
        .wr_weight (res_weight),
        .rd_en     (rd_en),
        .rd_addr   (rd_idx_reg[SLOT_BITS-1:0]),
        .key_from  (from_reg),
        .key_to    (to_reg),
        .rd_weight (rd_weight),
        .match     (match)
    );

    assign table_full = (count_reg == CNT_BITS'(TABLE_DEPTH));

    always_comb begin
        if (dup_reg) begin
            res_status = ST_DUPLICATE;
            res_weight = '0;
            res_slot   = dup_slot_reg;
        end else if (table_full) begin
            res_status = ST_FULL;
            res_weight = '0;
            res_slot   = '0;
        end else if (rev_found_reg) begin
            res_status = ST_REVERSE;
            res_weight = rev_wt_reg;
            res_slot   = count_reg[SLOT_BITS-1:0];
        end else begin
            res_status = ST_NEW;
            res_weight = wt_reg;
            res_slot   = count_reg[SLOT_BITS-1:0];
        end
    end

    assign res_weight_wide = 32'(res_weight);
    assign res_slot_wide   = 32'(res_slot);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            rev_found_reg <= 1'b0;
            dup_reg       <= 1'b0;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            rev_found_reg <= rev_found_next;
            dup_reg       <= dup_next;
            count_reg     <= count_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        from_reg     <= from_next;
        to_reg       <= to_next;
        wt_reg       <= wt_next;
        cmp_idx_reg  <= cmp_idx_next;
        rev_wt_reg   <= rev_wt_next;
        dup_slot_reg <= dup_slot_next;
        m_data_reg   <= m_data_next;
    end

    always_comb begin
        state_next     = state_reg;
        from_next      = from_reg;
        to_next        = to_reg;
        wt_next        = wt_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        rev_found_next = rev_found_reg;
        rev_wt_next    = rev_wt_reg;
        dup_next       = dup_reg;
        dup_slot_next  = dup_slot_reg;
        count_next     = count_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_data_next    = m_data_reg;
        s_axis_tready  = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        finish_fire    = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    from_next      = s_axis_tdata[VERTEX_BITS-1:0];
                    to_next        = s_axis_tdata[2*VERTEX_BITS-1:VERTEX_BITS];
                    wt_next        = s_axis_tdata[2*VERTEX_BITS+WEIGHT_BITS-1:2*VERTEX_BITS];
                    rd_idx_next    = '0;
                    cmp_valid_next = 1'b0;
                    rev_found_next = 1'b0;
                    dup_next       = 1'b0;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (cmp_valid_reg && match.dup) begin
                    dup_next       = 1'b1;
                    dup_slot_next  = cmp_idx_reg;
                    cmp_valid_next = 1'b0;
                    state_next     = S_FINISH;
                end else begin
                    if (cmp_valid_reg && match.rev && !rev_found_reg) begin
                        rev_found_next = 1'b1;
                        rev_wt_next    = rd_weight;
                    end
                    if (rd_idx_reg != count_reg) begin
                        rd_en          = 1'b1;
                        rd_idx_next    = rd_idx_reg + CNT_BITS'(1);
                        cmp_valid_next = 1'b1;
                        cmp_idx_next   = rd_idx_reg[SLOT_BITS-1:0];
                    end else begin
                        cmp_valid_next = 1'b0;
                        if (!cmp_valid_reg) begin
                            state_next = S_FINISH;
                        end
                    end
                end
            end
            S_FINISH: begin
                if (!m_valid_reg || m_axis_tready) begin
                    finish_fire  = 1'b1;
                    m_valid_next = 1'b1;
                    m_data_next  = {res_slot_wide[OUT_SLOT_BITS-1:0],
                                    res_weight_wide[OUT_WEIGHT_BITS-1:0],
                                    res_status};
                    if (!dup_reg && !table_full) begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_BITS'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(TABLE_DEPTH))
        else $error("live count beyond table depth");

    a_write_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> !table_full && !dup_reg)
        else $error("table write on full table or duplicate");

    a_dup_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (finish_fire && dup_reg) |=> $stable(count_reg))
        else $error("live count moved on duplicate");

    a_cmp_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_valid_reg |-> (state_reg == S_SCAN))
        else $error("compare pending outside scan");

endmodule

// ===== sv/etd_table.sv =====
// edge table memory with registered read port and shared entry comparator
module etd_table #(
    parameter int TABLE_DEPTH = 64,
    parameter int VERTEX_BITS = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
    input  logic [VERTEX_BITS-1:0]         wr_from,
    input  logic [VERTEX_BITS-1:0]         wr_to,
    input  logic [WEIGHT_BITS-1:0]         wr_weight,
    input  logic                           rd_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
    input  logic [VERTEX_BITS-1:0]         key_from,
    input  logic [VERTEX_BITS-1:0]         key_to,
    output logic [WEIGHT_BITS-1:0]         rd_weight,
    output etd_pkg::match_t                match
);
    import etd_pkg::*;

    localparam int ENTRY_BITS = 2 * VERTEX_BITS + WEIGHT_BITS;

    logic [ENTRY_BITS-1:0]  mem [TABLE_DEPTH];
    logic [ENTRY_BITS-1:0]  rd_entry_reg;
    logic [VERTEX_BITS-1:0] rd_from;
    logic [VERTEX_BITS-1:0] rd_to;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_weight, wr_to, wr_from};
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    assign rd_from   = rd_entry_reg[VERTEX_BITS-1:0];
    assign rd_to     = rd_entry_reg[2*VERTEX_BITS-1:VERTEX_BITS];
    assign rd_weight = rd_entry_reg[ENTRY_BITS-1:2*VERTEX_BITS];

    always_comb begin
        match.dup = (rd_from == key_from) && (rd_to == key_to);
        match.rev = (rd_from == key_to) && (rd_to == key_from);
    end

endmodule
